>>> rtl/tcw_pkg.sv
// tcw_pkg: shared types, codes and the microcode ROM of the text console character writer.
// Depends on nothing; used by tcw_cursor and text_console_char_writer_core.
`timescale 1ns / 1ps

package tcw_pkg;

  // Result kinds
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SCROLL = 2'd1;
  localparam logic [1:0] OP_CURSOR = 2'd2;

  // Character codes with special handling
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] ATTR_RESET = 8'h0F;

  // At most this many results per character; all but one may be writes or scrolls
  localparam int MAX_RESULTS = 10;
  localparam int NW          = 4;

  // Microcode step addresses
  localparam int PCW = 4;
  localparam logic [PCW-1:0] S_IDLE = 4'd0;
  localparam logic [PCW-1:0] S_BS   = 4'd1;
  localparam logic [PCW-1:0] S_BSW  = 4'd2;
  localparam logic [PCW-1:0] S_LF   = 4'd3;
  localparam logic [PCW-1:0] S_CR   = 4'd4;
  localparam logic [PCW-1:0] S_PRT  = 4'd5;
  localparam logic [PCW-1:0] S_TAB  = 4'd6;
  localparam logic [PCW-1:0] S_SCR  = 4'd7;
  localparam logic [PCW-1:0] S_CUR  = 4'd8;

  // Cursor datapath actions
  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_BACK = 3'd1,
    ACT_LF   = 3'd2,
    ACT_CR   = 3'd3,
    ACT_ADV  = 3'd4
  } act_t;

  // Jump conditions
  typedef enum logic [1:0] {
    C_ALWAYS   = 2'd0,
    C_BOTTOM   = 2'd1,
    C_WRAP_BOT = 2'd2
  } cond_t;

  // Low byte of a written cell
  typedef enum logic {
    W_CHAR  = 1'b0,
    W_BLANK = 1'b1
  } wsel_t;

  typedef struct packed {
    logic           emit;
    logic [1:0]     op;
    wsel_t          wsel;
    act_t           act;
    cond_t          cond;
    logic           tab_loop;
    logic [PCW-1:0] tgt_t;
    logic [PCW-1:0] tgt_f;
  } ctrl_t;

  // Status from the cursor datapath to the sequencer
  typedef struct packed {
    logic bottom;
    logic wrap_bottom;
  } cur_flags_t;

  // Entry step for a character
  function automatic logic [PCW-1:0] dispatch(input logic [7:0] ch);
    logic [PCW-1:0] s;
    case (ch)
      CH_NUL:  s = S_IDLE;
      CH_BS:   s = S_BS;
      CH_TAB:  s = S_TAB;
      CH_LF:   s = S_LF;
      CH_CR:   s = S_CR;
      default: s = S_PRT;
    endcase
    return s;
  endfunction

  // Microcode ROM: one control word per step
  function automatic ctrl_t ucode(input logic [PCW-1:0] pc);
    ctrl_t cw;
    cw.emit     = 1'b0;
    cw.op       = OP_WRITE;
    cw.wsel     = W_BLANK;
    cw.act      = ACT_NONE;
    cw.cond     = C_ALWAYS;
    cw.tab_loop = 1'b0;
    cw.tgt_t    = S_IDLE;
    cw.tgt_f    = S_IDLE;
    case (pc)
      S_BS: begin
        cw.act   = ACT_BACK;
        cw.tgt_t = S_BSW;
      end
      S_BSW: begin
        cw.emit  = 1'b1;
        cw.tgt_t = S_CUR;
      end
      S_LF: begin
        cw.act   = ACT_LF;
        cw.cond  = C_BOTTOM;
        cw.tgt_t = S_SCR;
        cw.tgt_f = S_CUR;
      end
      S_CR: begin
        cw.act   = ACT_CR;
        cw.tgt_t = S_CUR;
      end
      S_PRT: begin
        cw.emit  = 1'b1;
        cw.wsel  = W_CHAR;
        cw.act   = ACT_ADV;
        cw.cond  = C_WRAP_BOT;
        cw.tgt_t = S_SCR;
        cw.tgt_f = S_CUR;
      end
      S_TAB: begin
        cw.emit     = 1'b1;
        cw.act      = ACT_ADV;
        cw.cond     = C_WRAP_BOT;
        cw.tab_loop = 1'b1;
        cw.tgt_t    = S_SCR;
        cw.tgt_f    = S_CUR;
      end
      S_SCR: begin
        cw.emit  = 1'b1;
        cw.op    = OP_SCROLL;
        cw.tgt_t = S_CUR;
      end
      S_CUR: begin
        cw.emit  = 1'b1;
        cw.op    = OP_CURSOR;
        cw.tgt_t = S_IDLE;
      end
      default: begin
        cw.tgt_t = S_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

>>> rtl/text_console_char_writer_core.sv
// text_console_char_writer_core: microcoded character writer for a text screen.
// A character beat is taken only while idle, so one character is done before the next;
// each step gives at most one result beat, stalling only while the output is full and
// out_ready is low. Printable and backspace give one write, tab blank writes up to the
// stop; printable, tab and newline may add a scroll; all but NUL end in a cursor update.
// Reset (synchronous, rst_n low): cursor at (0,0), attribute 0x0F, output empty.
// Depends on tcw_pkg and tcw_cursor.
`timescale 1ns / 1ps

module text_console_char_writer_core #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_text_attribute,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_op_kind,
  output logic [6:0]  out_cell_col,
  output logic [4:0]  out_cell_row,
  output logic [15:0] out_cell_word,
  output logic [10:0] out_cursor_linear,
  output logic        out_last
);

  localparam int XW  = $clog2(COLUMNS);
  localparam int YW  = $clog2(ROWS);
  localparam int PW  = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int CW  = $clog2(TAB_WIDTH + 1);
  localparam int LW  = XW + YW + 1;
  localparam int PCW = tcw_pkg::PCW;
  localparam int NW  = tcw_pkg::NW;
  localparam logic [NW-1:0] N_LIMIT = NW'(tcw_pkg::MAX_RESULTS - 1);

  logic [PCW-1:0] pc_r, pc_nxt;
  logic [7:0]     char_r;
  logic [7:0]     attr_r;
  logic [NW-1:0]  n_r, n_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  tcw_pkg::ctrl_t      cw;
  tcw_pkg::cur_flags_t flags;
  logic [XW-1:0]  cur_x;
  logic [YW-1:0]  cur_y;
  logic [PW-1:0]  tab_ph;
  logic           accept, busy, emit_eff, slot_free, fire, load, cond_hit;
  logic [LW-1:0]  lin_full;

  logic        out_valid_r;
  logic [1:0]  op_r;
  logic [6:0]  col_r;
  logic [4:0]  row_r;
  logic [15:0] word_r;
  logic [10:0] lin_r;
  logic        last_r;

  // Control word of the current step
  assign cw        = tcw_pkg::ucode(pc_r);
  assign busy      = (pc_r != tcw_pkg::S_IDLE);
  assign in_ready  = !busy;
  assign accept    = in_valid && in_ready;
  assign emit_eff  = cw.emit && ((cw.op == tcw_pkg::OP_CURSOR) || (n_r < N_LIMIT));
  assign slot_free = !out_valid_r || out_ready;
  assign fire      = busy && (!emit_eff || slot_free);
  assign load      = fire && emit_eff;

  tcw_cursor #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_cursor (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (fire),
    .act_i       (cw.act),
    .cur_x_o     (cur_x),
    .cur_y_o     (cur_y),
    .tab_phase_o (tab_ph),
    .flags_o     (flags)
  );

  // Evaluate the jump condition
  always_comb begin
    case (cw.cond)
      tcw_pkg::C_ALWAYS:   cond_hit = 1'b1;
      tcw_pkg::C_BOTTOM:   cond_hit = flags.bottom;
      tcw_pkg::C_WRAP_BOT: cond_hit = flags.wrap_bottom;
      default:             cond_hit = 1'b0;
    endcase
  end

  // Advance the step counter, result count and tab counter
  always_comb begin
    pc_nxt  = pc_r;
    n_nxt   = n_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      pc_nxt  = tcw_pkg::dispatch(in_char_code);
      n_nxt   = '0;
      cnt_nxt = CW'(TAB_WIDTH) - CW'(tab_ph);
    end else if (fire) begin
      if (cond_hit) begin
        pc_nxt = cw.tgt_t;
      end else if (cw.tab_loop && (cnt_r > CW'(1))) begin
        pc_nxt = pc_r;
      end else begin
        pc_nxt = cw.tgt_f;
      end
      if (load && (cw.op != tcw_pkg::OP_CURSOR)) begin
        n_nxt = n_r + NW'(1);
      end
      if (cw.tab_loop) begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= tcw_pkg::S_IDLE;
      n_r    <= '0;
      cnt_r  <= '0;
      attr_r <= tcw_pkg::ATTR_RESET;
    end else begin
      pc_r  <= pc_nxt;
      n_r   <= n_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        attr_r <= cfg_text_attribute;
      end
    end
  end

  // Hold the character of the beat in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      char_r <= in_char_code;
    end
  end

  assign lin_full = LW'(cur_y) * LW'(COLUMNS) + LW'(cur_x);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r   <= cw.op;
      last_r <= (cw.op == tcw_pkg::OP_CURSOR);
      col_r  <= (cw.op == tcw_pkg::OP_SCROLL) ? 7'd0 : 7'(cur_x);
      row_r  <= (cw.op == tcw_pkg::OP_SCROLL) ? 5'd0 : 5'(cur_y);
      lin_r  <= (cw.op == tcw_pkg::OP_CURSOR) ? 11'(lin_full) : 11'd0;
      if (cw.op == tcw_pkg::OP_CURSOR) begin
        word_r <= 16'd0;
      end else if ((cw.op == tcw_pkg::OP_WRITE) && (cw.wsel == tcw_pkg::W_CHAR)) begin
        word_r <= {attr_r, char_r};
      end else begin
        word_r <= {attr_r, tcw_pkg::CH_SPACE};
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_op_kind       = op_r;
  assign out_cell_col      = col_r;
  assign out_cell_row      = row_r;
  assign out_cell_word     = word_r;
  assign out_cursor_linear = lin_r;
  assign out_last          = last_r;

  // Cursor update ends the character and frees the input
  a_cur_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (pc_r == tcw_pkg::S_CUR)) |=> in_ready)
    else $error("sequencer did not return to idle after cursor update");
  // Result count never passes the limit
  a_n_limit: assert property (@(posedge clk) disable iff (!rst_n) n_r <= N_LIMIT)
    else $error("result count over limit");
  // Tab loop always has blanks left
  a_tab_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == tcw_pkg::S_TAB) |-> (cnt_r != '0))
    else $error("tab step with no blanks left");
  // Last flag marks exactly the cursor update
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (last_r == (op_r == tcw_pkg::OP_CURSOR)))
    else $error("last flag on wrong result kind");

endmodule

>>> rtl/tcw_cursor.sv
// tcw_cursor: cursor column, row and tab phase registers with their update actions.
// Depends on tcw_pkg for the action codes and the flag struct.
`timescale 1ns / 1ps

module tcw_cursor #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_i,
  input  tcw_pkg::act_t                act_i,
  output logic [$clog2(COLUMNS)-1:0]   cur_x_o,
  output logic [$clog2(ROWS)-1:0]      cur_y_o,
  output logic [((TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1)-1:0] tab_phase_o,
  output tcw_pkg::cur_flags_t          flags_o
);

  localparam int XW = $clog2(COLUMNS);
  localparam int YW = $clog2(ROWS);
  localparam int PW = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam logic [XW-1:0] X_LAST      = XW'(COLUMNS - 1);
  localparam logic [YW-1:0] Y_LAST      = YW'(ROWS - 1);
  localparam logic [PW-1:0] PH_LAST     = PW'(TAB_WIDTH - 1);
  localparam logic [PW-1:0] PH_COL_LAST = PW'((COLUMNS - 1) % TAB_WIDTH);

  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic [PW-1:0] ph_r, ph_nxt;
  logic [PW-1:0] ph_inc, ph_dec;

  // Tab phase tracks column modulo the tab width
  assign ph_inc = (ph_r == PH_LAST) ? '0 : ph_r + PW'(1);
  assign ph_dec = (ph_r == '0) ? PH_LAST : ph_r - PW'(1);

  assign flags_o.bottom      = (y_r == Y_LAST);
  assign flags_o.wrap_bottom = (y_r == Y_LAST) && (x_r == X_LAST);

  // Apply the step's cursor action
  always_comb begin
    x_nxt  = x_r;
    y_nxt  = y_r;
    ph_nxt = ph_r;
    if (step_i) begin
      case (act_i)
        tcw_pkg::ACT_BACK: begin
          if (x_r != '0) begin
            x_nxt  = x_r - XW'(1);
            ph_nxt = ph_dec;
          end else if (y_r != '0) begin
            x_nxt  = X_LAST;
            y_nxt  = y_r - YW'(1);
            ph_nxt = PH_COL_LAST;
          end
        end
        tcw_pkg::ACT_LF: begin
          x_nxt  = '0;
          ph_nxt = '0;
          if (y_r != Y_LAST) begin
            y_nxt = y_r + YW'(1);
          end
        end
        tcw_pkg::ACT_CR: begin
          x_nxt  = '0;
          ph_nxt = '0;
        end
        tcw_pkg::ACT_ADV: begin
          if (x_r != X_LAST) begin
            x_nxt  = x_r + XW'(1);
            ph_nxt = ph_inc;
          end else begin
            x_nxt  = '0;
            ph_nxt = '0;
            if (y_r != Y_LAST) begin
              y_nxt = y_r + YW'(1);
            end
          end
        end
        default: begin
          x_nxt = x_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r  <= '0;
      y_r  <= '0;
      ph_r <= '0;
    end else begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      ph_r <= ph_nxt;
    end
  end

  assign cur_x_o     = x_r;
  assign cur_y_o     = y_r;
  assign tab_phase_o = ph_r;

  // Cursor stays on the screen
  a_x_range: assert property (@(posedge clk) disable iff (!rst_n) x_r <= X_LAST)
    else $error("cursor column left the screen");
  a_y_range: assert property (@(posedge clk) disable iff (!rst_n) y_r <= Y_LAST)
    else $error("cursor row left the screen");
  // Phase 0 at column 0
  a_ph_home: assert property (@(posedge clk) disable iff (!rst_n)
    (x_r == '0) |-> (ph_r == '0))
    else $error("tab phase out of step with column");

endmodule
